### design/spq_pkg.sv
package spq_pkg;

	localparam int unsigned DEPTH_DEF     = 64;
	localparam int unsigned KEY_WIDTH_DEF = 20;

	typedef enum logic {
		ACT_ENQ = 1'b0,
		ACT_DEQ = 1'b1
	} action_t;

	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic push;
		logic pop;
		logic load;
		logic flag_empty;
		logic flag_full;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

### design/spq_req_if.sv
interface spq_req_if #(
	parameter int unsigned KEY_WIDTH = 20
);
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [KEY_WIDTH-1:0] key_in;

	modport source (output valid, output action, output key_in, input ready);
	modport sink (input valid, input action, input key_in, output ready);
endinterface

### design/spq_rsp_if.sv
interface spq_rsp_if #(
	parameter int unsigned KEY_WIDTH = 20,
	parameter int unsigned CNT_WIDTH = 7
);
	logic                 valid;
	logic                 ready;
	logic [KEY_WIDTH-1:0] key_out;
	logic                 was_empty;
	logic                 was_full;
	logic [CNT_WIDTH-1:0] occupancy;

	modport source (output valid, output key_out, output was_empty, output was_full,
		output occupancy, input ready);
	modport sink (input valid, input key_out, input was_empty, input was_full,
		input occupancy, output ready);
endinterface

### design/spq_ctrl.sv
module spq_ctrl
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_action,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        fire;
	logic        is_deq;

	assign is_deq = (action_t'(in_action) == ACT_DEQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a held result may leave in the same cycle a new transaction comes in
	always_comb begin
		in_ready  = (state_q == ST_IDLE) || out_ready;
		fire      = in_valid && in_ready;
		out_valid = (state_q == ST_HOLD);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (fire) state_d = ST_HOLD;
				else if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load       = fire;
		cmd.push       = fire && !is_deq && !stat.full;
		cmd.pop        = fire && is_deq && !stat.empty;
		cmd.flag_full  = !is_deq && stat.full;
		cmd.flag_empty = is_deq && stat.empty;
	end

endmodule

### design/spq_datapath.sv
module spq_datapath
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH     = DEPTH_DEF,
	parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int unsigned CNT_WIDTH = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [KEY_WIDTH-1:0] key_in,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output logic [KEY_WIDTH-1:0] key_out,
	output logic                 was_empty,
	output logic                 was_full,
	output logic [CNT_WIDTH-1:0] occupancy
);

	logic [KEY_WIDTH-1:0] entries_q [DEPTH];
	logic [CNT_WIDTH-1:0] count_q, count_d;
	logic [DEPTH-1:0]     le;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_comb begin
		priority if (cmd.push) count_d = count_q + CNT_WIDTH'(1);
		else if (cmd.pop) count_d = count_q - CNT_WIDTH'(1);
		else count_d = count_q;
	end

	assign stat.full  = (count_q == CNT_WIDTH'(DEPTH));
	assign stat.empty = (count_q == '0);

	// row of cells: each compares against the new key and takes its own,
	// the new key or its lower neighbour on insert, its upper neighbour on removal
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_WIDTH-1:0] ins_val;
		logic [KEY_WIDTH-1:0] rem_val;

		assign le[i] = (count_q > CNT_WIDTH'(i)) && (entries_q[i] <= key_in);

		if (i == 0) begin : g_head
			assign ins_val = le[i] ? entries_q[i] : key_in;
		end else begin : g_body
			assign ins_val = le[i] ? entries_q[i] : (le[i-1] ? key_in : entries_q[i-1]);
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rem_val = entries_q[i];
		end else begin : g_mid
			assign rem_val = entries_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.push) begin
				entries_q[i] <= ins_val;
			end else if (cmd.pop) begin
				entries_q[i] <= rem_val;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_out   <= cmd.pop ? entries_q[0] : '0;
			was_empty <= cmd.flag_empty;
			was_full  <= cmd.flag_full;
			occupancy <= count_d;
		end
	end

endmodule

### design/sorted_priority_queue.sv
// Min-priority queue of up to DEPTH unsigned keys, held in ascending order in a
// row of compare-and-shift cells. An enqueue (action 0) slots its key in after
// every stored key less than or equal to it, so equal keys leave in arrival
// order; a dequeue (action 1) returns the smallest key. Each transaction on req
// yields exactly one transaction on rsp carrying the occupancy after it.
// Dequeue on an empty queue returns key 0 with was_empty set; enqueue on a full
// queue drops the key and sets was_full. The cell row completes an insert or
// removal as the transaction is accepted, and the result sits in an output
// register, so a new transaction is taken each cycle whenever rsp is ready or
// its register is empty. The result appears in the cycle after acceptance.
// No clearing pass is needed after reset.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH     = DEPTH_DEF,
	parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
	input logic  clk,
	input logic  arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spq_datapath #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH),
		.CNT_WIDTH (CNT_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_in    (req.key_in),
		.cmd       (cmd),
		.stat      (stat),
		.key_out   (rsp.key_out),
		.was_empty (rsp.was_empty),
		.was_full  (rsp.was_full),
		.occupancy (rsp.occupancy)
	);

endmodule

### design/spq_checker.sv
module spq_checker
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH     = DEPTH_DEF,
	parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int unsigned CNT_WIDTH = $clog2(DEPTH + 1)
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic [KEY_WIDTH-1:0] key_out,
	input logic                 was_empty,
	input logic                 was_full,
	input logic [CNT_WIDTH-1:0] occupancy
);

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= CNT_WIDTH'(DEPTH)))
		else $error("occupancy beyond depth");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_empty && was_full))
		else $error("empty and full flags together");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_empty) |-> (key_out == '0 && occupancy == '0))
		else $error("empty dequeue result malformed");

	a_full_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_full) |-> (occupancy == CNT_WIDTH'(DEPTH) && key_out == '0))
		else $error("dropped enqueue result malformed");

	// every accepted transaction shows its result on the next cycle
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("result missing after transaction");

endmodule

bind sorted_priority_queue spq_checker #(
	.DEPTH     (DEPTH),
	.KEY_WIDTH (KEY_WIDTH),
	.CNT_WIDTH (CNT_WIDTH)
) u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.key_out   (rsp.key_out),
	.was_empty (rsp.was_empty),
	.was_full  (rsp.was_full),
	.occupancy (rsp.occupancy)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import spq_pkg::*;

	localparam int unsigned DEPTH_N  = DEPTH_DEF;
	localparam int unsigned KEY_W    = KEY_WIDTH_DEF;
	localparam int unsigned CNT_W    = $clog2(DEPTH_N + 1);
	localparam int          N_RANDOM = 1000;
	localparam int          LIMIT    = 400000;
	localparam int          HOLD_LEN = 300;

	typedef struct {
		action_t          act;
		logic [KEY_W-1:0] key;
	} pq_op_t;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic             empty;
		logic             full;
		logic [CNT_W-1:0] occ;
	} pq_result_t;

	logic clk;
	logic arst_n;

	spq_req_if #(.KEY_WIDTH(KEY_W)) req_if ();
	spq_rsp_if #(.KEY_WIDTH(KEY_W), .CNT_WIDTH(CNT_W)) rsp_if ();

	sorted_priority_queue #(
		.DEPTH(DEPTH_N),
		.KEY_WIDTH(KEY_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	pq_op_t           pending_ops[$];
	pq_result_t       expected_results[$];
	logic [KEY_W-1:0] model_keys[DEPTH_N];
	int               model_count;
	int               gen_count;
	int               errors;
	int               results_seen;
	int               cycles;
	int               send_idle;
	int               send_burst;
	int               recv_stall;
	int               recv_burst;
	int               hold_left;
	int               holds_done;
	pq_result_t       got_exp;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, a few long ones, and now and then a run with none at all
	function automatic int pick_gap(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return '1;
			2, 3, 4: return KEY_W'($urandom_range(0, 15));
			default: return KEY_W'($urandom());
		endcase
	endfunction

	// gen_count tracks occupancy while the stimulus is built, to steer fill and drain runs
	function automatic void add_op(action_t act, logic [KEY_W-1:0] key);
		pq_op_t op;
		op.act = act;
		op.key = key;
		pending_ops.push_back(op);
		if (act == ACT_ENQ) begin
			if (gen_count < DEPTH_N)
				gen_count++;
		end else if (gen_count > 0) begin
			gen_count--;
		end
	endfunction

	function automatic pq_result_t apply_op(action_t act, logic [KEY_W-1:0] key);
		pq_result_t res;
		int         pos;
		res.key   = '0;
		res.empty = 1'b0;
		res.full  = 1'b0;
		if (act == ACT_ENQ) begin
			if (model_count >= DEPTH_N) begin
				res.full = 1'b1;
			end else begin
				// new key goes after all equal keys
				pos = model_count;
				while (pos > 0 && model_keys[pos-1] > key) begin
					model_keys[pos] = model_keys[pos-1];
					pos--;
				end
				model_keys[pos] = key;
				model_count++;
			end
		end else begin
			if (model_count == 0) begin
				res.empty = 1'b1;
			end else begin
				res.key = model_keys[0];
				for (pos = 1; pos < model_count; pos++)
					model_keys[pos-1] = model_keys[pos];
				model_count--;
			end
		end
		res.occ = CNT_W'(model_count);
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid  <= 1'b0;
			req_if.action <= ACT_ENQ;
			req_if.key_in <= '0;
			send_idle = 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				expected_results.push_back(apply_op(action_t'(req_if.action), req_if.key_in));
				void'(pending_ops.pop_front());
			end
			if (!req_if.valid || req_if.ready) begin
				if (send_idle > 0) begin
					send_idle--;
					req_if.valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					req_if.valid  <= 1'b1;
					req_if.action <= pending_ops[0].act;
					req_if.key_in <= pending_ops[0].key;
					send_idle = pick_gap(send_burst);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver, with two long holds so the queue backs up and stalls req
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			recv_stall = 0;
			hold_left  = 0;
		end else begin
			if (hold_left == 0 && ((holds_done == 0 && results_seen >= 150) ||
					(holds_done == 1 && results_seen >= 700))) begin
				hold_left = HOLD_LEN;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				recv_stall = pick_gap(recv_burst);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing expected: key_out %0h occupancy %0d",
					rsp_if.key_out, rsp_if.occupancy);
				errors++;
			end else begin
				got_exp = expected_results.pop_front();
				if (rsp_if.key_out !== got_exp.key) begin
					$error("key_out: expected %0h, got %0h", got_exp.key, rsp_if.key_out);
					errors++;
				end
				if (rsp_if.was_empty !== got_exp.empty) begin
					$error("was_empty: expected %0b, got %0b", got_exp.empty, rsp_if.was_empty);
					errors++;
				end
				if (rsp_if.was_full !== got_exp.full) begin
					$error("was_full: expected %0b, got %0b", got_exp.full, rsp_if.was_full);
					errors++;
				end
				if (rsp_if.occupancy !== got_exp.occ) begin
					$error("occupancy: expected %0d, got %0d", got_exp.occ, rsp_if.occupancy);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int phase;
		int len;
		int i;
		req_if.valid  = 1'b0;
		req_if.action = ACT_ENQ;
		req_if.key_in = '0;
		rsp_if.ready  = 1'b0;
		arst_n        = 1'b0;
		model_count   = 0;
		gen_count     = 0;
		errors        = 0;
		results_seen  = 0;
		cycles        = 0;
		send_burst    = 0;
		recv_burst    = 0;
		holds_done    = 0;

		// directed: dequeue on empty, key extremes, ties, key ignored on dequeue
		add_op(ACT_DEQ, '1);
		add_op(ACT_ENQ, '1);
		add_op(ACT_ENQ, '0);
		add_op(ACT_ENQ, KEY_W'(5));
		add_op(ACT_ENQ, KEY_W'(5));
		add_op(ACT_ENQ, KEY_W'(5));
		add_op(ACT_ENQ, KEY_W'(1) << (KEY_W - 1));
		add_op(ACT_ENQ, KEY_W'(3));
		add_op(ACT_DEQ, KEY_W'(7));
		for (i = 0; i < 7; i++)
			add_op(ACT_DEQ, pick_key());
		add_op(ACT_DEQ, '0);

		// random: fill runs that overflow, drain runs that underflow, mixed runs
		phase = 0;
		while (pending_ops.size() < N_RANDOM + 17) begin
			case (phase)
				0: begin
					while (gen_count < DEPTH_N) begin
						if ($urandom_range(0, 9) == 0)
							add_op(ACT_DEQ, pick_key());
						else
							add_op(ACT_ENQ, pick_key());
					end
					len = $urandom_range(1, 3);
					for (i = 0; i < len; i++)
						add_op(ACT_ENQ, pick_key());
				end
				1: begin
					while (gen_count > 0) begin
						if ($urandom_range(0, 9) == 0)
							add_op(ACT_ENQ, pick_key());
						else
							add_op(ACT_DEQ, pick_key());
					end
					len = $urandom_range(1, 3);
					for (i = 0; i < len; i++)
						add_op(ACT_DEQ, pick_key());
				end
				default: begin
					len = $urandom_range(20, 60);
					for (i = 0; i < len; i++)
						add_op(action_t'($urandom_range(0, 1)), pick_key());
				end
			endcase
			phase = $urandom_range(0, 2);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
